// ===== design/record_scan_predicate_filter_defines.svh =====
// ----------------------------------------------------------------------------
// record scan predicate filter assertion macros
// shared macros for the concurrent checks in the top level
// ----------------------------------------------------------------------------
`ifndef RECORD_SCAN_PREDICATE_FILTER_DEFINES_SVH
`define RECORD_SCAN_PREDICATE_FILTER_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define RSPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked during reset too
`define RSPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/rspf_pkg.sv =====
// ----------------------------------------------------------------------------
// rspf_pkg
// shared types and constants of the record scan predicate filter
// ----------------------------------------------------------------------------
`default_nettype none
package rspf_pkg;

  localparam int MaxRecordBytesDef = 4096;
  localparam int FilterBytesDef    = 8;

  localparam logic [1:0] TYPE_STRING = 2'd0;
  localparam logic [1:0] TYPE_INT    = 2'd1;
  localparam logic [1:0] TYPE_FLOAT  = 2'd2;

  localparam logic [2:0] OP_LT  = 3'd0;
  localparam logic [2:0] OP_LTE = 3'd1;
  localparam logic [2:0] OP_EQ  = 3'd2;
  localparam logic [2:0] OP_GTE = 3'd3;
  localparam logic [2:0] OP_GT  = 3'd4;
  localparam logic [2:0] OP_NE  = 3'd5;

  localparam logic [1:0] SV_EQUAL   = 2'd0;
  localparam logic [1:0] SV_LESS    = 2'd1;
  localparam logic [1:0] SV_GREATER = 2'd2;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_LENGTH = 3'd2;
  localparam logic [2:0] REG_TYPE   = 3'd3;
  localparam logic [2:0] REG_OP     = 3'd4;
  localparam logic [2:0] REG_FILTER = 3'd5;

  typedef struct packed {
    logic        filter_enable;
    logic [11:0] attr_offset;
    logic [3:0]  attr_length;
    logic [1:0]  attr_type;
    logic [2:0]  compare_op;
    logic [63:0] filter_value;
  } cfg_t;

  typedef struct packed {
    logic        match;
    logic        too_short;
  } result_t;

endpackage
`default_nettype wire

// ===== design/rspf_in_if.sv =====
// ----------------------------------------------------------------------------
// rspf_in_if
// record byte channel: one byte word per handshake with a last-byte mark
// ----------------------------------------------------------------------------
`default_nettype none
interface rspf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== design/rspf_out_if.sv =====
// ----------------------------------------------------------------------------
// rspf_out_if
// result channel: one match word per record
// ----------------------------------------------------------------------------
`default_nettype none
interface rspf_out_if;
  logic valid;
  logic ready;
  logic match;
  logic too_short;
  modport source (output valid, output match, output too_short, input ready);
  modport sink (input valid, input match, input too_short, output ready);
endinterface
`default_nettype wire

// ===== design/rspf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rspf_cfg_regs
// apb register file holding the filter configuration
// ----------------------------------------------------------------------------
`default_nettype none
module rspf_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready,
  output rspf_pkg::cfg_t   cfg
);
  import rspf_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_enable <= 1'b0;
      cfg_r.attr_offset   <= 12'd0;
      cfg_r.attr_length   <= 4'd4;
      cfg_r.attr_type     <= TYPE_INT;
      cfg_r.compare_op    <= OP_EQ;
      cfg_r.filter_value  <= 64'd0;
    end else if (wr_en && cfg_paddr[2:0] == 3'd0) begin
      case (reg_idx)
        REG_ENABLE: cfg_r.filter_enable <= cfg_pwdata[0];
        REG_OFFSET: cfg_r.attr_offset   <= cfg_pwdata[11:0];
        REG_LENGTH: cfg_r.attr_length   <= cfg_pwdata[3:0];
        REG_TYPE:   cfg_r.attr_type     <= cfg_pwdata[1:0];
        REG_OP:     cfg_r.compare_op    <= cfg_pwdata[2:0];
        REG_FILTER: cfg_r.filter_value  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 64'd0;
    case (reg_idx)
      REG_ENABLE: cfg_prdata = {63'd0, cfg_r.filter_enable};
      REG_OFFSET: cfg_prdata = {52'd0, cfg_r.attr_offset};
      REG_LENGTH: cfg_prdata = {60'd0, cfg_r.attr_length};
      REG_TYPE:   cfg_prdata = {62'd0, cfg_r.attr_type};
      REG_OP:     cfg_prdata = {61'd0, cfg_r.compare_op};
      REG_FILTER: cfg_prdata = cfg_r.filter_value;
      default:    cfg_prdata = 64'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/rspf_compare.sv =====
// ----------------------------------------------------------------------------
// rspf_compare
// final predicate from captured attribute state and the operator
// ----------------------------------------------------------------------------
`default_nettype none
module rspf_compare (
  input  wire rspf_pkg::cfg_t cfg,
  input  wire logic [31:0]    attr_word,
  input  wire logic [1:0]     str_verdict,
  input  wire logic           too_short,
  output rspf_pkg::result_t   res
);
  import rspf_pkg::*;

  logic [31:0] fw;
  logic        lt, gt, un;
  logic        a_nan, b_nan, a_zero, b_zero, a_neg, b_neg;
  logic        mag_lt, mag_gt;
  logic        m;

  assign fw     = cfg.filter_value[31:0];
  assign a_nan  = (attr_word[30:23] == 8'hff) && (attr_word[22:0] != 23'd0);
  assign b_nan  = (fw[30:23] == 8'hff) && (fw[22:0] != 23'd0);
  assign a_zero = attr_word[30:0] == 31'd0;
  assign b_zero = fw[30:0] == 31'd0;
  assign a_neg  = attr_word[31];
  assign b_neg  = fw[31];
  assign mag_lt = attr_word[30:0] < fw[30:0];
  assign mag_gt = attr_word[30:0] > fw[30:0];

  always_comb begin
    lt = 1'b0;
    gt = 1'b0;
    un = 1'b0;
    case (cfg.attr_type)
      TYPE_STRING: begin
        lt = str_verdict == SV_LESS;
        gt = str_verdict == SV_GREATER;
      end
      TYPE_INT: begin
        lt = $signed(attr_word) < $signed(fw);
        gt = $signed(attr_word) > $signed(fw);
      end
      TYPE_FLOAT: begin
        if (a_nan || b_nan) begin
          un = 1'b1;
        end else if (a_zero && b_zero) begin
          lt = 1'b0;
        end else if (a_neg != b_neg) begin
          lt = a_neg;
          gt = b_neg;
        end else if (a_neg) begin
          lt = mag_gt;
          gt = mag_lt;
        end else begin
          lt = mag_lt;
          gt = mag_gt;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cfg.compare_op)
      OP_LT:   m = !un && lt;
      OP_LTE:  m = !un && !gt;
      OP_EQ:   m = !un && !lt && !gt;
      OP_GTE:  m = !un && !lt;
      OP_GT:   m = !un && gt;
      OP_NE:   m = un || lt || gt;
      default: m = 1'b0;
    endcase
    if (!cfg.filter_enable) begin
      res.match     = 1'b1;
      res.too_short = 1'b0;
    end else if (too_short) begin
      res.match     = 1'b0;
      res.too_short = 1'b1;
    end else begin
      res.match     = m;
      res.too_short = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== design/record_scan_predicate_filter.sv =====
// ----------------------------------------------------------------------------
// record_scan_predicate_filter
// per-record predicate match over a byte stream
// ----------------------------------------------------------------------------
// Takes one record byte per cycle, back to back, unless the result stalls,
// and gives one match word per record in the cycle after the last byte is
// taken. Each accepted byte updates the record state (position, captured
// attribute bytes, running string verdict); on the last byte the compare
// logic forms the verdict into the result register. A new byte is accepted
// whenever the result register is empty or being drained.
`default_nettype none
`include "record_scan_predicate_filter_defines.svh"
module record_scan_predicate_filter #(
  parameter int MAX_RECORD_BYTES = rspf_pkg::MaxRecordBytesDef,
  parameter int FILTER_BYTES     = rspf_pkg::FilterBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rspf_in_if.sink          in_ch,
  rspf_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import rspf_pkg::*;

  localparam int PW = $clog2(MAX_RECORD_BYTES + 1) + 1;
  localparam int EW = (PW > 13) ? PW : 13;

  cfg_t        cfg;
  result_t     res;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  verd_r, verd_nxt;
  logic        stop_r, stop_nxt;
  logic        ovalid_r;
  logic [1:0]  odata_r;
  logic        acc;
  logic [3:0]  win_len;
  logic [EW-1:0] p_ext, off_ext, end_ext, idx;
  logic        in_win, short_rec;
  logic [7:0]  fbyte;
  logic [7:0]  b;

  rspf_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  assign in_ch.ready      = !ovalid_r || out_ch.ready;
  assign acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = ovalid_r;
  assign out_ch.match     = odata_r[1];
  assign out_ch.too_short = odata_r[0];
  assign b                = in_ch.data_byte;

  always_comb begin
    if (cfg.attr_type == TYPE_INT || cfg.attr_type == TYPE_FLOAT) begin
      win_len = 4'd4;
    end else if (cfg.attr_length == 4'd0) begin
      win_len = 4'd1;
    end else if (32'(cfg.attr_length) > FILTER_BYTES) begin
      win_len = 4'(FILTER_BYTES);
    end else begin
      win_len = cfg.attr_length;
    end
  end

  assign p_ext   = EW'(pos_r);
  assign off_ext = EW'(cfg.attr_offset);
  assign end_ext = off_ext + EW'(win_len);
  assign idx     = p_ext - off_ext;
  assign in_win  = (p_ext >= off_ext) && (p_ext < end_ext);
  assign fbyte   = cfg.filter_value[8*idx[2:0] +: 8];
  assign short_rec = (end_ext > p_ext + EW'(1)) || (end_ext > EW'(MAX_RECORD_BYTES));

  always_comb begin
    word_nxt = word_r;
    verd_nxt = verd_r;
    stop_nxt = stop_r;
    pos_nxt  = pos_r;
    if (in_win) begin
      if (cfg.attr_type == TYPE_STRING) begin
        if (!stop_r && idx < EW'(FILTER_BYTES)) begin
          if (b != fbyte) begin
            verd_nxt = (b < fbyte) ? SV_LESS : SV_GREATER;
            stop_nxt = 1'b1;
          end else if (b == 8'd0) begin
            stop_nxt = 1'b1;
          end
        end
      end else if (idx < EW'(4)) begin
        word_nxt = word_r | (32'(b) << (8 * idx[1:0]));
      end
    end
    if (p_ext < EW'(MAX_RECORD_BYTES)) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  rspf_compare u_cmp (
    .cfg, .attr_word(word_nxt), .str_verdict(verd_nxt), .too_short(short_rec), .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      word_r   <= '0;
      verd_r   <= SV_EQUAL;
      stop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      if (acc) begin
        if (in_ch.last_byte) begin
          pos_r    <= '0;
          word_r   <= '0;
          verd_r   <= SV_EQUAL;
          stop_r   <= 1'b0;
          ovalid_r <= 1'b1;
        end else begin
          pos_r  <= pos_nxt;
          word_r <= word_nxt;
          verd_r <= verd_nxt;
          stop_r <= stop_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.last_byte) begin
      odata_r <= {res.match, res.too_short};
    end
  end

  `RSPF_ASSERT(a_short_no_match, out_ch.valid |-> !(out_ch.match && out_ch.too_short),
    "too-short record reported as match")
  `RSPF_ASSERT(a_pos_cleared, $past(acc && in_ch.last_byte) |-> pos_r == '0,
    "position not cleared after record end")
  `RSPF_ASSERT(a_stall_hold, (out_ch.valid && !out_ch.ready) |-> !in_ch.ready,
    "input taken while result stalled")
  `RSPF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_ch.valid,
    "result valid after reset")
endmodule
`default_nettype wire
